/* hdl/hmg_pkg.sv */
// heightmap mesh generator package: payload structs, configuration struct,
// register indexes and fixed arithmetic constants
// no dependencies
`timescale 1ns / 1ps

package hmg_pkg;

    typedef struct packed {
        logic [7:0] height_sample;
    } t_sample;

    typedef struct packed {
        logic [9:0]  pos_x;
        logic [15:0] pos_y;
        logic [15:0] pos_z;
        logic [15:0] tex_u;
        logic [15:0] tex_v;
        logic        last_of_cell;
    } t_vertex;

    typedef struct packed {
        logic [10:0] grid_width;
        logic [15:0] grid_height;
        logic [15:0] max_height;
        logic [15:0] u_step;
        logic [15:0] v_step;
    } t_cfg;

    // one completed grid cell: bottom-right corner coordinates and four samples
    typedef struct packed {
        logic [15:0] col;
        logic [15:0] row;
        logic [7:0]  s_up;
        logic [7:0]  s_ul;
        logic [7:0]  s_left;
        logic [7:0]  s_cur;
    } t_cell;

    typedef enum logic [2:0] {
        REG_GRID_WIDTH  = 3'd0,
        REG_GRID_HEIGHT = 3'd1,
        REG_MAX_HEIGHT  = 3'd2,
        REG_U_STEP      = 3'd3,
        REG_V_STEP      = 3'd4
    } t_reg_idx;

    localparam logic [10:0] RST_GRID_WIDTH  = 11'd256;
    localparam logic [15:0] RST_GRID_HEIGHT = 16'd256;
    localparam logic [15:0] RST_MAX_HEIGHT  = 16'd7680;
    localparam logic [15:0] RST_U_STEP      = 16'd256;
    localparam logic [15:0] RST_V_STEP      = 16'd256;

    localparam logic [15:0] MIN_DIM     = 16'd2;
    localparam logic [2:0]  LAST_CORNER = 3'd5;

    // divide by 255: multiply by 0x8081 and shift by 23, then one correction
    localparam logic [15:0] RECIP_255  = 16'h8081;
    localparam int          RecipShift = 23;
    localparam int          EstW       = 17;

endpackage

/* hdl/hmg_stream_if.sv */
// valid/ready stream interface carrying one payload of type T
// no dependencies
`timescale 1ns / 1ps

interface hmg_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/hmg_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module hmg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* hdl/hmg_fifo.sv */
// small register queue between front and back end
// depends on nothing but its type parameter
`timescale 1ns / 1ps

module hmg_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  T     i_push_data,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output T     o_pop_data
);
    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

    T                r_mem [DEPTH];
    logic [PtrW-1:0] r_wptr;
    logic [PtrW-1:0] r_rptr;
    logic [CntW-1:0] r_count;
    logic            push;
    logic            pop;

    assign o_push_ready = (r_count != Full);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == LastPtr) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == LastPtr) ? '0 : r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end
endmodule

/* hdl/hmg_front.sv */
// front end: takes samples, tracks column and row, keeps the line buffer
// and hands each completed cell to the queue; uses hmg_pkg, hmg_ram, hmg_stream_if
`timescale 1ns / 1ps

module hmg_front import hmg_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    hmg_stream_if.sink  i_sample,
    output logic        o_cell_valid,
    input  logic        i_cell_ready,
    output t_cell       o_cell
);
    localparam int          AddrW = $clog2(MAX_WIDTH);
    localparam logic [15:0] MaxW  = 16'(MAX_WIDTH);

    logic [AddrW-1:0] r_col;
    logic [AddrW-1:0] n_col;
    logic [15:0]      r_row;
    logic [15:0]      n_row;
    logic [7:0]       r_left;
    logic [7:0]       r_ul;

    logic             r_b_valid;
    logic             r_b_emit;
    logic [7:0]       r_b_s;
    logic [15:0]      r_b_col;
    logic [15:0]      r_b_row;

    logic [15:0]      w_lim;
    logic [15:0]      h_lim;
    logic [15:0]      a_col;
    logic [15:0]      a_row;
    logic             a_col_last;
    logic             a_row_last;
    logic             accept;
    logic             b_fire;
    logic [7:0]       upper;

    // effective bounds and the position of the incoming sample
    always_comb begin
        priority if (i_cfg.grid_width < 11'd2) begin
            w_lim = MIN_DIM;
        end else if ({5'b0, i_cfg.grid_width} > MaxW) begin
            w_lim = MaxW;
        end else begin
            w_lim = {5'b0, i_cfg.grid_width};
        end
        h_lim      = (i_cfg.grid_height < MIN_DIM) ? MIN_DIM : i_cfg.grid_height;
        a_col      = (16'(r_col) >= w_lim) ? 16'd0 : 16'(r_col);
        a_row      = (r_row >= h_lim) ? 16'd0 : r_row;
        a_col_last = ({1'b0, a_col} + 17'd1) >= {1'b0, w_lim};
        a_row_last = ({1'b0, a_row} + 17'd1) >= {1'b0, h_lim};
        n_col      = a_col_last ? '0 : AddrW'(a_col + 16'd1);
        n_row      = a_col_last ? (a_row_last ? 16'd0 : a_row + 16'd1) : a_row;
    end

    assign b_fire         = r_b_valid && (!r_b_emit || i_cell_ready);
    assign i_sample.ready = !r_b_valid || b_fire;
    assign accept         = i_sample.valid && i_sample.ready;

    // read old value and store the new sample at the same column
    hmg_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (AddrW'(a_col)),
        .i_wdata (i_sample.data.height_sample),
        .i_re    (accept),
        .i_raddr (AddrW'(a_col)),
        .o_rdata (upper)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_left    <= '0;
            r_ul      <= '0;
            r_b_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (accept) begin
                r_b_valid <= 1'b1;
            end else if (b_fire) begin
                r_b_valid <= 1'b0;
            end
            if (b_fire) begin
                r_left <= r_b_s;
                r_ul   <= upper;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_s    <= i_sample.data.height_sample;
            r_b_col  <= a_col;
            r_b_row  <= a_row;
            r_b_emit <= (a_col != 16'd0) && (a_row != 16'd0);
        end
    end

    assign o_cell_valid  = r_b_valid && r_b_emit;
    assign o_cell.col    = r_b_col;
    assign o_cell.row    = r_b_row;
    assign o_cell.s_up   = upper;
    assign o_cell.s_ul   = r_ul;
    assign o_cell.s_left = r_left;
    assign o_cell.s_cur  = r_b_s;
endmodule

/* hdl/hmg_back.sv */
// back end: walks each queued cell through its six corners and computes
// height and texture coordinates in a four stage pipeline; uses hmg_pkg, hmg_stream_if
`timescale 1ns / 1ps

module hmg_back import hmg_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    input  logic         i_cell_valid,
    output logic         o_cell_ready,
    input  t_cell        i_cell,
    hmg_stream_if.source o_vertex
);
    logic [2:0]      r_corner;
    logic            en;
    logic            issue;
    logic            corner_last;
    logic [15:0]     sel_x;
    logic [15:0]     sel_z;
    logic [7:0]      sel_s;

    logic            r1_valid;
    logic [15:0]     r1_x;
    logic [15:0]     r1_z;
    logic [7:0]      r1_s;
    logic            r1_last;

    logic            r2_valid;
    logic [23:0]     r2_prod;
    logic [15:0]     r2_x;
    logic [15:0]     r2_z;
    logic [15:0]     r2_u;
    logic [15:0]     r2_v;
    logic            r2_last;

    logic            r3_valid;
    logic [23:0]     r3_prod;
    logic [EstW-1:0] r3_est;
    logic [15:0]     r3_x;
    logic [15:0]     r3_z;
    logic [15:0]     r3_u;
    logic [15:0]     r3_v;
    logic            r3_last;

    logic            r4_valid;
    t_vertex         r4_vtx;

    logic [23:0]     prod;
    logic [31:0]     u_full;
    logic [31:0]     v_full;
    logic [39:0]     est_full;
    logic [24:0]     est_x255;
    logic [EstW-1:0] quot;

    assign en          = !r4_valid || o_vertex.ready;
    assign issue       = en && i_cell_valid;
    assign corner_last = (r_corner == LAST_CORNER);
    assign o_cell_ready = en && corner_last;

    // corner order 1,0,2,2,3,1 around the cell
    always_comb begin
        unique case (r_corner)
            3'd0: begin
                sel_x = i_cell.col;
                sel_z = i_cell.row - 16'd1;
                sel_s = i_cell.s_up;
            end
            3'd1: begin
                sel_x = i_cell.col - 16'd1;
                sel_z = i_cell.row - 16'd1;
                sel_s = i_cell.s_ul;
            end
            3'd2, 3'd3: begin
                sel_x = i_cell.col - 16'd1;
                sel_z = i_cell.row;
                sel_s = i_cell.s_left;
            end
            3'd4: begin
                sel_x = i_cell.col;
                sel_z = i_cell.row;
                sel_s = i_cell.s_cur;
            end
            default: begin
                sel_x = i_cell.col;
                sel_z = i_cell.row - 16'd1;
                sel_s = i_cell.s_up;
            end
        endcase
    end

    always_comb begin
        prod     = r1_s * i_cfg.max_height;
        u_full   = r1_x * i_cfg.u_step;
        v_full   = r1_z * i_cfg.v_step;
        est_full = r2_prod * RECIP_255;
        est_x255 = {r3_est, 8'b0} - 25'(r3_est);
        quot     = (est_x255 > {1'b0, r3_prod}) ? r3_est - 1'b1 : r3_est;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner <= '0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (en) begin
            if (issue) begin
                r_corner <= corner_last ? 3'd0 : r_corner + 3'd1;
            end
            r1_valid <= issue;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_x    <= sel_x;
            r1_z    <= sel_z;
            r1_s    <= sel_s;
            r1_last <= corner_last;

            r2_prod <= prod;
            r2_x    <= r1_x;
            r2_z    <= r1_z;
            r2_u    <= u_full[15:0];
            r2_v    <= v_full[15:0];
            r2_last <= r1_last;

            r3_prod <= r2_prod;
            r3_est  <= est_full[RecipShift +: EstW];
            r3_x    <= r2_x;
            r3_z    <= r2_z;
            r3_u    <= r2_u;
            r3_v    <= r2_v;
            r3_last <= r2_last;

            r4_vtx.pos_x        <= r3_x[9:0];
            r4_vtx.pos_y        <= quot[15:0];
            r4_vtx.pos_z        <= r3_z;
            r4_vtx.tex_u        <= r3_u;
            r4_vtx.tex_v        <= r3_v;
            r4_vtx.last_of_cell <= r3_last;
        end
    end

    assign o_vertex.valid = r4_valid;
    assign o_vertex.data  = r4_vtx;
endmodule

/* hdl/heightmap_mesh_generator.sv */
// heightmap mesh generator top level: register port, front end, cell queue, back end
// uses hmg_pkg, hmg_stream_if, hmg_front, hmg_fifo, hmg_back
`timescale 1ns / 1ps

// Takes 8-bit heightmap samples in raster order on i_sample and returns triangle
// vertices on o_vertex, six per grid cell (corners 1,0,2,2,3,1), the sixth flagged
// by last_of_cell. A sample in row 0 or column 0 gives no vertex; every other
// sample gives six vertices, produced one per cycle while o_vertex is ready by
// the back end corner sequencer, which takes a new cell only after its sixth
// corner is issued. A two-entry cell queue lets the input keep moving while
// the output stalls. The line buffer has no reset; registers are written over
// the APB port at 4*index.

module heightmap_mesh_generator import hmg_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hmg_stream_if.sink   i_sample,
    hmg_stream_if.source o_vertex,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     cfg_wr;
    logic     front_valid;
    logic     front_ready;
    t_cell    front_cell;
    logic     back_valid;
    logic     back_ready;
    t_cell    back_cell;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_width  <= RST_GRID_WIDTH;
            r_cfg.grid_height <= RST_GRID_HEIGHT;
            r_cfg.max_height  <= RST_MAX_HEIGHT;
            r_cfg.u_step      <= RST_U_STEP;
            r_cfg.v_step      <= RST_V_STEP;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_GRID_WIDTH:  r_cfg.grid_width  <= pwdata[10:0];
                REG_GRID_HEIGHT: r_cfg.grid_height <= pwdata[15:0];
                REG_MAX_HEIGHT:  r_cfg.max_height  <= pwdata[15:0];
                REG_U_STEP:      r_cfg.u_step      <= pwdata[15:0];
                REG_V_STEP:      r_cfg.v_step      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_GRID_WIDTH:  prdata = {21'b0, r_cfg.grid_width};
            REG_GRID_HEIGHT: prdata = {16'b0, r_cfg.grid_height};
            REG_MAX_HEIGHT:  prdata = {16'b0, r_cfg.max_height};
            REG_U_STEP:      prdata = {16'b0, r_cfg.u_step};
            REG_V_STEP:      prdata = {16'b0, r_cfg.v_step};
            default:         prdata = 32'd0;
        endcase
    end

    hmg_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_sample     (i_sample),
        .o_cell_valid (front_valid),
        .i_cell_ready (front_ready),
        .o_cell       (front_cell)
    );

    hmg_fifo #(
        .T     (t_cell),
        .DEPTH (2)
    ) u_cell_q (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_data  (front_cell),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_pop_data   (back_cell)
    );

    hmg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_cell_valid (back_valid),
        .o_cell_ready (back_ready),
        .i_cell       (back_cell),
        .o_vertex     (o_vertex)
    );
endmodule
